[rtl/pma_pkg.sv]
// Shared constants, types and helpers for the point-mass acceleration pipeline.
package pma_pkg;

   localparam int unsigned LANES      = 3;
   localparam int unsigned REQ_W      = 304;
   localparam int unsigned RSP_W      = 96;
   localparam int unsigned RSP_USER_W = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 50;

   localparam int unsigned SQRT_STEPS = 32;
   localparam int unsigned DIV_STEPS  = 64;

   localparam logic [49:0] GP_RESET = 50'd398600441800000;
   localparam logic [25:0] ER_RESET = 26'd6371000;
   localparam logic [23:0] AH_RESET = 24'd100000;
   localparam logic [31:0] KD_RESET = 32'd0;

   localparam logic [62:0] DIV_CAP    = 63'h4000_0000_0000_0000;
   localparam logic [9:0]  KILO       = 10'd1000;
   localparam logic [25:0] DRAG_SCALE = 26'd65536000;

   localparam logic signed [65:0] ACC_MAX = 66'sd2147483647;
   localparam logic signed [65:0] ACC_MIN = -66'sd2147483648;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_GRAV_PARAM   = 2'd0,
      REG_EARTH_RADIUS = 2'd1,
      REG_ATMOS_HEIGHT = 2'd2,
      REG_DRAG_COEFF   = 2'd3
   } csr_reg_type;

   // Per-item data that rides alongside the square-root pipeline
   typedef struct packed {
      logic [31:0]            mass;
      logic [2:0][31:0]       pmag;
      logic [2:0]             pneg;
      logic [2:0][31:0]       vmag;
      logic [2:0]             vneg;
      logic [2:0]             dneg;
      logic [2:0][56:0]       tnum;
      logic [63:0]            r2;
   } side_type;

   // Per-lane data that rides alongside the dividers
   typedef struct packed {
      logic [31:0] r;
      logic        gon;
      logic        don;
      logic        pneg;
      logic        vneg;
      logic        dneg;
      logic        mzero;
      logic [62:0] thr;
      logic [62:0] drg;
   } tag_type;

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [15:0] mag16(input logic [15:0] v);
      return v[15] ? (~v + 16'd1) : v;
   endfunction

endpackage

[rtl/pma_isqrt.sv]
// Pipelined digit-by-digit integer square root of two 64-bit radicands.
module pma_isqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   vld_in,
   input  logic [1:0][63:0]       rad_in,
   input  pma_pkg::side_type      side_in,
   output logic                   vld_out,
   output logic [1:0][31:0]       root_out,
   output pma_pkg::side_type      side_out
);

   logic [pma_pkg::SQRT_STEPS-1:0] vld_ff;
   logic [1:0][63:0]               xs_ff   [pma_pkg::SQRT_STEPS];
   logic [1:0][33:0]               rem_ff  [pma_pkg::SQRT_STEPS];
   logic [1:0][31:0]               root_ff [pma_pkg::SQRT_STEPS];
   pma_pkg::side_type              side_ff [pma_pkg::SQRT_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[pma_pkg::SQRT_STEPS-2:0], vld_in};
      end
   end

   for (genvar k = 0; k < pma_pkg::SQRT_STEPS; k++) begin : g_stage
      logic [1:0][63:0]  xs_src;
      logic [1:0][33:0]  rem_src;
      logic [1:0][31:0]  root_src;
      pma_pkg::side_type side_src;
      logic [1:0][63:0]  xs_in;
      logic [1:0][33:0]  rem_in;
      logic [1:0][31:0]  root_in;

      if (k == 0) begin : g_first
         assign xs_src   = rad_in;
         assign rem_src  = '0;
         assign root_src = '0;
         assign side_src = side_in;
      end else begin : g_next
         assign xs_src   = xs_ff[k-1];
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         logic [35:0] rem_sh;
         logic [35:0] trial;
         logic        ge;
         for (int i = 0; i < 2; i++) begin
            rem_sh     = {rem_src[i], xs_src[i][63:62]};
            trial      = {2'b00, root_src[i], 2'b01};
            ge         = rem_sh >= trial;
            rem_in[i]  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
            root_in[i] = {root_src[i][30:0], ge};
            xs_in[i]   = {xs_src[i][61:0], 2'b00};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            xs_ff[k]   <= xs_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign vld_out  = vld_ff[pma_pkg::SQRT_STEPS-1];
   assign root_out = root_ff[pma_pkg::SQRT_STEPS-1];
   assign side_out = side_ff[pma_pkg::SQRT_STEPS-1];

endmodule

[rtl/pma_div.sv]
// Pipelined restoring divider: 128-bit dividend by 64-bit divisor, quotient held at 2^62.
module pma_div (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             vld_in,
   input  logic [63:0]      num_hi,
   input  logic [63:0]      num_lo,
   input  logic [63:0]      den,
   input  pma_pkg::tag_type tag_in,
   output logic             vld_out,
   output logic [62:0]      quo_out,
   output pma_pkg::tag_type tag_out
);

   logic [pma_pkg::DIV_STEPS:0] vld_ff;
   logic [63:0]                 rem_ff [pma_pkg::DIV_STEPS+1];
   logic [63:0]                 quo_ff [pma_pkg::DIV_STEPS+1];
   logic [63:0]                 den_ff [pma_pkg::DIV_STEPS+1];
   logic [pma_pkg::DIV_STEPS:0] cap_ff;
   pma_pkg::tag_type            tag_ff [pma_pkg::DIV_STEPS+1];
   logic                        out_vld_ff;
   logic [62:0]                 out_quo_ff;
   logic [62:0]                 out_quo_in;
   pma_pkg::tag_type            out_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[pma_pkg::DIV_STEPS-1:0], vld_in};
         out_vld_ff <= vld_ff[pma_pkg::DIV_STEPS];
      end
   end

   // Entry: a high half at or above the divisor already overflows the cap
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num_hi;
         quo_ff[0] <= num_lo;
         den_ff[0] <= den;
         cap_ff[0] <= num_hi >= den;
         tag_ff[0] <= tag_in;
      end
   end

   for (genvar k = 1; k <= pma_pkg::DIV_STEPS; k++) begin : g_step
      logic [64:0] part;
      logic [64:0] diff;
      logic        ge;
      logic [63:0] rem_in;
      logic [63:0] quo_in;

      always_comb begin
         part   = {rem_ff[k-1], quo_ff[k-1][63]};
         diff   = part - {1'b0, den_ff[k-1]};
         ge     = part >= {1'b0, den_ff[k-1]};
         rem_in = ge ? diff[63:0] : part[63:0];
         quo_in = {quo_ff[k-1][62:0], ge};
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= quo_in;
            den_ff[k] <= den_ff[k-1];
            cap_ff[k] <= cap_ff[k-1];
            tag_ff[k] <= tag_ff[k-1];
         end
      end
   end

   always_comb begin
      if (cap_ff[pma_pkg::DIV_STEPS] ||
          quo_ff[pma_pkg::DIV_STEPS] > {1'b0, pma_pkg::DIV_CAP}) begin
         out_quo_in = pma_pkg::DIV_CAP;
      end else begin
         out_quo_in = quo_ff[pma_pkg::DIV_STEPS][62:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_quo_ff <= out_quo_in;
         out_tag_ff <= tag_ff[pma_pkg::DIV_STEPS];
      end
   end

   assign vld_out = out_vld_ff;
   assign quo_out = out_quo_ff;
   assign tag_out = out_tag_ff;

endmodule

[rtl/point_mass_acceleration.sv]
// Top level of the point-mass acceleration pipeline: gravity, thrust and drag.
//
// One item on req_ (position, velocity, mass, thrust, direction) yields one
// result on rsp_ (acceleration vector plus mass_error and saturated flags).
// Items are independent; a new one is taken every cycle while the pipeline
// moves. The pipeline has 3 input/product stages, 32 square-root stages,
// 3 product stages, two chained dividers (gravity takes 1000*GM*|p|/r^2
// and then /r; thrust and drag divide alongside the first), one summing
// stage and the output register.
// Throughput is one item per cycle. When rsp_tready is low with a result
// waiting, every stage holds and req_tready drops in the same cycle; nothing
// is lost or repeated.
// The csr_ channel is always ready and takes one register write per transfer;
// write it only while no item is in flight.
// Reset is synchronous and active high: it empties the pipeline and loads
// the default gravitational parameter, earth radius, atmosphere height and a
// zero drag coefficient.
module point_mass_acceleration (
   input  logic                             clock,
   input  logic                             reset,
   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, body_mass, thrust_force,
   // dir_x, dir_y, dir_z
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [pma_pkg::REQ_W-1:0]        req_tdata,
   // accel_x, accel_y, accel_z
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [pma_pkg::RSP_W-1:0]        rsp_tdata,
   // mass_error, saturated
   output logic [pma_pkg::RSP_USER_W-1:0]   rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pma_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pma_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int unsigned L = pma_pkg::LANES;

   logic        en;
   logic [49:0] gp_ff;
   logic [25:0] er_ff;
   logic [23:0] ah_ff;
   logic [31:0] kd_ff;

   // Stage P0: captured input
   logic                      p0_vld_ff;
   logic [pma_pkg::REQ_W-1:0] p0_data_ff;

   // Stage P1: magnitudes and squares
   logic                 p1_vld_ff;
   logic [L-1:0][63:0]   p1_psq_ff, p1_psq_in;
   logic [L-1:0][63:0]   p1_vsq_ff, p1_vsq_in;
   logic [L-1:0][46:0]   p1_tn_ff, p1_tn_in;
   logic [L-1:0][31:0]   p1_pmag_ff, p1_pmag_in;
   logic [L-1:0][31:0]   p1_vmag_ff, p1_vmag_in;
   logic [L-1:0]         p1_pneg_ff, p1_pneg_in;
   logic [L-1:0]         p1_vneg_ff, p1_vneg_in;
   logic [L-1:0]         p1_dneg_ff, p1_dneg_in;
   logic [31:0]          p1_mass_ff;

   // Stage P2: sums of squares
   logic                 p2_vld_ff;
   logic [1:0][63:0]     p2_rad_ff, p2_rad_in;
   pma_pkg::side_type    p2_side_ff, p2_side_in;

   logic                 sq_vld;
   logic [1:0][31:0]     sq_root;
   pma_pkg::side_type    sq_side;

   // Stages Q1..Q3: products feeding the dividers
   logic [59:0]          gm1000;
   logic                 q1_vld_ff;
   logic [31:0]          q1_r_ff;
   logic                 q1_gon_ff, q1_gon_in;
   logic                 q1_don_ff, q1_don_in;
   logic [L-1:0][63:0]   q1_ppgl_ff, q1_ppgl_in;
   logic [L-1:0][59:0]   q1_ppgh_ff, q1_ppgh_in;
   logic [63:0]          q1_ks_ff;
   pma_pkg::side_type    q1_side_ff;

   logic                 q2_vld_ff;
   logic [31:0]          q2_r_ff;
   logic                 q2_gon_ff;
   logic                 q2_don_ff;
   logic [L-1:0][91:0]   q2_gprod_ff, q2_gprod_in;
   logic [L-1:0][63:0]   q2_ppdl_ff, q2_ppdl_in;
   logic [L-1:0][63:0]   q2_ppdh_ff, q2_ppdh_in;
   logic [57:0]          q2_dden_ff;
   pma_pkg::side_type    q2_side_ff;

   logic                 q3_vld_ff;
   logic [L-1:0][91:0]   q3_gprod_ff;
   logic [L-1:0][95:0]   q3_dprod_ff, q3_dprod_in;
   logic [57:0]          q3_dden_ff;
   logic [46:0]          q3_tden_ff;
   pma_pkg::side_type    q3_side_ff;
   pma_pkg::tag_type     q3_tag_ff [L];
   pma_pkg::tag_type     q3_tag_in [L];

   // Divider outputs
   logic [L-1:0]         fin_vld;
   logic [62:0]          fin_quo [L];
   pma_pkg::tag_type     fin_tag [L];

   // Sum and output stages
   logic                       sm_vld_ff;
   logic                       sm_mzero_ff;
   logic signed [L-1:0][65:0]  sm_sum_ff, sm_sum_in;

   logic                             rsp_tvalid_ff;
   logic [pma_pkg::RSP_W-1:0]        rsp_tdata_ff, rsp_tdata_in;
   logic [pma_pkg::RSP_USER_W-1:0]   rsp_tuser_ff, rsp_tuser_in;

   // Whole pipeline advances unless a finished result is stalled
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;
   assign csr_ready  = 1'b1;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         gp_ff <= pma_pkg::GP_RESET;
         er_ff <= pma_pkg::ER_RESET;
         ah_ff <= pma_pkg::AH_RESET;
         kd_ff <= pma_pkg::KD_RESET;
      end else if (csr_valid) begin
         unique case (pma_pkg::csr_reg_type'(csr_index))
            pma_pkg::REG_GRAV_PARAM:   gp_ff <= csr_data;
            pma_pkg::REG_EARTH_RADIUS: er_ff <= csr_data[25:0];
            pma_pkg::REG_ATMOS_HEIGHT: ah_ff <= csr_data[23:0];
            pma_pkg::REG_DRAG_COEFF:   kd_ff <= csr_data[31:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- valids
   always_ff @(posedge clock) begin
      if (reset) begin
         p0_vld_ff     <= 1'b0;
         p1_vld_ff     <= 1'b0;
         p2_vld_ff     <= 1'b0;
         q1_vld_ff     <= 1'b0;
         q2_vld_ff     <= 1'b0;
         q3_vld_ff     <= 1'b0;
         sm_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         p0_vld_ff     <= req_tvalid;
         p1_vld_ff     <= p0_vld_ff;
         p2_vld_ff     <= p1_vld_ff;
         q1_vld_ff     <= sq_vld;
         q2_vld_ff     <= q1_vld_ff;
         q3_vld_ff     <= q2_vld_ff;
         sm_vld_ff     <= &fin_vld;
         rsp_tvalid_ff <= sm_vld_ff;
      end
   end

   // ---------------------------------------------------------------- P0/P1
   always_comb begin
      logic [31:0] pv;
      logic [31:0] vv;
      logic [15:0] dv;
      logic [15:0] dmag;
      logic [47:0] tn;
      for (int i = 0; i < L; i++) begin
         pv            = p0_data_ff[32*i +: 32];
         vv            = p0_data_ff[96 + 32*i +: 32];
         dv            = p0_data_ff[256 + 16*i +: 16];
         dmag          = pma_pkg::mag16(dv);
         p1_pmag_in[i] = pma_pkg::mag32(pv);
         p1_vmag_in[i] = pma_pkg::mag32(vv);
         p1_pneg_in[i] = pv[31];
         p1_vneg_in[i] = vv[31];
         p1_dneg_in[i] = dv[15];
         p1_psq_in[i]  = 64'(p1_pmag_in[i]) * 64'(p1_pmag_in[i]);
         p1_vsq_in[i]  = 64'(p1_vmag_in[i]) * 64'(p1_vmag_in[i]);
         tn            = 48'(p0_data_ff[255:224]) * 48'(dmag);
         p1_tn_in[i]   = tn[46:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p0_data_ff <= req_tdata;
         p1_psq_ff  <= p1_psq_in;
         p1_vsq_ff  <= p1_vsq_in;
         p1_tn_ff   <= p1_tn_in;
         p1_pmag_ff <= p1_pmag_in;
         p1_vmag_ff <= p1_vmag_in;
         p1_pneg_ff <= p1_pneg_in;
         p1_vneg_ff <= p1_vneg_in;
         p1_dneg_ff <= p1_dneg_in;
         p1_mass_ff <= p0_data_ff[223:192];
      end
   end

   // ---------------------------------------------------------------- P2
   always_comb begin
      p2_rad_in[0] = p1_psq_ff[0] + p1_psq_ff[1] + p1_psq_ff[2];
      p2_rad_in[1] = p1_vsq_ff[0] + p1_vsq_ff[1] + p1_vsq_ff[2];
      p2_side_in.mass = p1_mass_ff;
      p2_side_in.pmag = p1_pmag_ff;
      p2_side_in.pneg = p1_pneg_ff;
      p2_side_in.vmag = p1_vmag_ff;
      p2_side_in.vneg = p1_vneg_ff;
      p2_side_in.dneg = p1_dneg_ff;
      p2_side_in.r2   = p2_rad_in[0];
      for (int i = 0; i < L; i++) begin
         p2_side_in.tnum[i] = 57'(p1_tn_ff[i]) * 57'(pma_pkg::KILO);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p2_rad_ff  <= p2_rad_in;
         p2_side_ff <= p2_side_in;
      end
   end

   pma_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .vld_in   (p2_vld_ff),
      .rad_in   (p2_rad_ff),
      .side_in  (p2_side_ff),
      .vld_out  (sq_vld),
      .root_out (sq_root),
      .side_out (sq_side)
   );

   // ---------------------------------------------------------------- Q1..Q3
   assign gm1000 = 60'(gp_ff) * 60'(pma_pkg::KILO);

   always_comb begin
      logic [26:0] rh;
      rh        = {1'b0, er_ff} + {3'b000, ah_ff};
      q1_gon_in = {sq_root[0], 1'b0} > {7'd0, er_ff};
      q1_don_in = sq_root[0] < {5'd0, rh};
      for (int i = 0; i < L; i++) begin
         q1_ppgl_in[i] = 64'(gm1000[31:0]) * 64'(sq_side.pmag[i]);
         q1_ppgh_in[i] = 60'(gm1000[59:32]) * 60'(sq_side.pmag[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q1_r_ff    <= sq_root[0];
         q1_gon_ff  <= q1_gon_in;
         q1_don_ff  <= q1_don_in;
         q1_ppgl_ff <= q1_ppgl_in;
         q1_ppgh_ff <= q1_ppgh_in;
         q1_ks_ff   <= 64'(kd_ff) * 64'(sq_root[1]);
         q1_side_ff <= sq_side;
      end
   end

   always_comb begin
      for (int i = 0; i < L; i++) begin
         q2_gprod_in[i] = {q1_ppgh_ff[i], 32'd0} + {28'd0, q1_ppgl_ff[i]};
         q2_ppdl_in[i]  = 64'(q1_ks_ff[31:0]) * 64'(q1_side_ff.vmag[i]);
         q2_ppdh_in[i]  = 64'(q1_ks_ff[63:32]) * 64'(q1_side_ff.vmag[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q2_r_ff     <= q1_r_ff;
         q2_gon_ff   <= q1_gon_ff;
         q2_don_ff   <= q1_don_ff;
         q2_gprod_ff <= q2_gprod_in;
         q2_ppdl_ff  <= q2_ppdl_in;
         q2_ppdh_ff  <= q2_ppdh_in;
         q2_dden_ff  <= 58'(q1_side_ff.mass) * 58'(pma_pkg::DRAG_SCALE);
         q2_side_ff  <= q1_side_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < L; i++) begin
         q3_dprod_in[i]     = {q2_ppdh_ff[i], 32'd0} + {32'd0, q2_ppdl_ff[i]};
         q3_tag_in[i].r     = q2_r_ff;
         q3_tag_in[i].gon   = q2_gon_ff;
         q3_tag_in[i].don   = q2_don_ff;
         q3_tag_in[i].pneg  = q2_side_ff.pneg[i];
         q3_tag_in[i].vneg  = q2_side_ff.vneg[i];
         q3_tag_in[i].dneg  = q2_side_ff.dneg[i];
         q3_tag_in[i].mzero = q2_side_ff.mass == 32'd0;
         q3_tag_in[i].thr   = '0;
         q3_tag_in[i].drg   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q3_gprod_ff <= q2_gprod_ff;
         q3_dprod_ff <= q3_dprod_in;
         q3_dden_ff  <= q2_dden_ff;
         q3_tden_ff  <= {q2_side_ff.mass, 15'd0};
         q3_side_ff  <= q2_side_ff;
         for (int i = 0; i < L; i++) begin
            q3_tag_ff[i] <= q3_tag_in[i];
         end
      end
   end

   // ---------------------------------------------------------------- dividers
   for (genvar g = 0; g < L; g++) begin : g_lane
      logic             grav_vld;
      logic [62:0]      grav_quo;
      pma_pkg::tag_type grav_tag;
      logic [62:0]      thr_quo;
      logic [62:0]      drg_quo;
      pma_pkg::tag_type mid_tag;

      pma_div u_div_grav (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .vld_in  (q3_vld_ff),
         .num_hi  ({36'd0, q3_gprod_ff[g][91:64]}),
         .num_lo  (q3_gprod_ff[g][63:0]),
         .den     (q3_side_ff.r2),
         .tag_in  (q3_tag_ff[g]),
         .vld_out (grav_vld),
         .quo_out (grav_quo),
         .tag_out (grav_tag)
      );

      pma_div u_div_thr (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .vld_in  (q3_vld_ff),
         .num_hi  (64'd0),
         .num_lo  ({7'd0, q3_side_ff.tnum[g]}),
         .den     ({17'd0, q3_tden_ff}),
         .tag_in  ('0),
         .vld_out (),
         .quo_out (thr_quo),
         .tag_out ()
      );

      pma_div u_div_drg (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .vld_in  (q3_vld_ff),
         .num_hi  ({32'd0, q3_dprod_ff[g][95:64]}),
         .num_lo  (q3_dprod_ff[g][63:0]),
         .den     ({6'd0, q3_dden_ff}),
         .tag_in  ('0),
         .vld_out (),
         .quo_out (drg_quo),
         .tag_out ()
      );

      always_comb begin
         mid_tag     = grav_tag;
         mid_tag.thr = thr_quo;
         mid_tag.drg = drg_quo;
      end

      // Second gravity division by r; thrust and drag ride in the tag
      pma_div u_div_fin (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .vld_in  (grav_vld),
         .num_hi  (64'd0),
         .num_lo  ({1'b0, grav_quo}),
         .den     ({32'd0, grav_tag.r}),
         .tag_in  (mid_tag),
         .vld_out (fin_vld[g]),
         .quo_out (fin_quo[g]),
         .tag_out (fin_tag[g])
      );
   end

   // ---------------------------------------------------------------- sum
   always_comb begin
      logic signed [65:0] gt;
      logic signed [65:0] tt;
      logic signed [65:0] dt;
      for (int i = 0; i < L; i++) begin
         gt = fin_tag[i].gon ? $signed({3'b000, fin_quo[i]}) : 66'sd0;
         tt = $signed({3'b000, fin_tag[i].thr});
         dt = fin_tag[i].don ? $signed({3'b000, fin_tag[i].drg}) : 66'sd0;
         if (!fin_tag[i].pneg) gt = -gt;
         if (fin_tag[i].dneg)  tt = -tt;
         if (!fin_tag[i].vneg) dt = -dt;
         sm_sum_in[i] = gt + tt + dt;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sm_sum_ff   <= sm_sum_in;
         sm_mzero_ff <= fin_tag[0].mzero;
      end
   end

   // ---------------------------------------------------------------- clamp
   always_comb begin
      logic sat;
      sat = 1'b0;
      for (int i = 0; i < L; i++) begin
         // elements of a packed array select as unsigned
         if ($signed(sm_sum_ff[i]) > pma_pkg::ACC_MAX) begin
            rsp_tdata_in[32*i +: 32] = 32'h7FFF_FFFF;
            sat = 1'b1;
         end else if ($signed(sm_sum_ff[i]) < pma_pkg::ACC_MIN) begin
            rsp_tdata_in[32*i +: 32] = 32'h8000_0000;
            sat = 1'b1;
         end else begin
            rsp_tdata_in[32*i +: 32] = sm_sum_ff[i][31:0];
         end
      end
      if (sm_mzero_ff) begin
         rsp_tdata_in = '0;
         sat          = 1'b0;
      end
      rsp_tuser_in = {sat, sm_mzero_ff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

[rtl/pma_checker.sv]
// Port-level checks for the point-mass acceleration block, bound to the top level.
module pma_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [pma_pkg::RSP_W-1:0]        rsp_tdata,
   input logic [pma_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   // Pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // An empty output register never blocks the input side
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // A mass error gives zero acceleration and no saturation
   a_mass_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("mass error with nonzero result");

   // Saturation shows up as a clamped component
   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |->
         rsp_tdata[31:0] == 32'h7FFF_FFFF || rsp_tdata[31:0] == 32'h8000_0000 ||
         rsp_tdata[63:32] == 32'h7FFF_FFFF || rsp_tdata[63:32] == 32'h8000_0000 ||
         rsp_tdata[95:64] == 32'h7FFF_FFFF || rsp_tdata[95:64] == 32'h8000_0000)
      else $error("saturated flag without clamped component");

   // Stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind point_mass_acceleration pma_checker u_pma_checker (.*);
